// ===== hdl/bqc_pkg.sv =====
// Shared types and constants for the biquad cascade filter.
package bqc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SIG_W     = 24;
   localparam int COEF_W    = 20;
   localparam int COEF_FRAC = 16;
   localparam int SLOTS     = 5;
   localparam int HIST      = 4;
   localparam int CFG_W     = 5;
   localparam int SEC_IDX_W = 4;
   localparam int SLOT_W    = 3;
   localparam int CMD_W     = 2;
   localparam int PROD_W    = SIG_W + COEF_W;
   localparam int ACC_W     = PROD_W + 3;

   localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   localparam logic [1:0] H_X1 = 2'd0;
   localparam logic [1:0] H_X2 = 2'd1;
   localparam logic [1:0] H_Y1 = 2'd2;
   localparam logic [1:0] H_Y2 = 2'd3;

   localparam logic [SLOT_W-1:0] TERM_X1 = 3'd0;
   localparam logic [SLOT_W-1:0] TERM_X2 = 3'd1;
   localparam logic [SLOT_W-1:0] TERM_Y1 = 3'd2;
   localparam logic [SLOT_W-1:0] TERM_Y2 = 3'd3;
   localparam logic [SLOT_W-1:0] TERM_X0 = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [SEC_IDX_W-1:0]    section_index;
      logic [SLOT_W-1:0]       coefficient_slot;
      logic signed [COEF_W-1:0] coefficient_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       saturated;
   } rsp_type;

   typedef logic [SLOTS-1:0][COEF_W-1:0] coef_row_type;
   typedef logic [HIST-1:0][SIG_W-1:0]   hist_row_type;

endpackage

// ===== hdl/biquad_cascade_iir_filter.sv =====
// Biquad cascade filter top level: sequencer, shared multiply-accumulate, stores.
//
//   channel  ports            dir  payload
//   req      req_valid/ready  in   bqc_pkg::req_type
//   rsp      rsp_valid/ready  out  bqc_pkg::rsp_type
//   csr      csr_wr_en        in   sections_in_use, 5 bits
//
// A filter beat keeps the block busy until its result is loaded; one shared multiplier
// does five products for each of the N sections in use.
// Load and clear beats leave the block ready and give no result.
// After reset a clearing pass over all MAX_SECTIONS sections zeroes the coefficients.
// A result left waiting in the output register stalls the next filter beat in its last cycle.
module biquad_cascade_iir_filter #(
   parameter int MAX_SECTIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bqc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bqc_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bqc_pkg::CFG_W-1:0]     csr_wr_data
);
   import bqc_pkg::*;

   localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SHIFT = SIG_W - SAMPLE_W;
   localparam int OUT_W = SIG_W + 1;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] ACC_SIG_MAX = ACC_W'({1'b0, {(SIG_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] ACC_SIG_MIN = ~ACC_SIG_MAX;
   localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
   localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_HALF = OUT_W'(1) << (SHIFT - 1);
   localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
   localparam logic signed [OUT_W-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   state_type state_ff, state_in;
   logic [SEC_W-1:0] clr_ff, clr_in, sec_ff, sec_in, last_ff, last_in;
   logic [SEC_W-1:0] rd_sec, cfg_last;
   logic [SLOT_W-1:0] term_ff, term_in;
   logic [CFG_W-1:0] sections_ff;
   logic rsp_valid_ff, rsp_valid_in, load_out;
   logic prod_vld_ff, wb1_ff, wb2_ff;
   logic [MAX_SECTIONS-1:0] hist_valid_ff;

   logic req_beat, filter_beat, load_we, clear_beat, last_term;

   coef_row_type coef_mem [MAX_SECTIONS];
   hist_row_type hist_mem [MAX_SECTIONS];
   coef_row_type coef_row_ff;
   hist_row_type hist_row_ff, hist_use, hist_wr;
   logic hist_ok_ff;

   logic signed [COEF_W-1:0] mul_c;
   logic signed [SIG_W-1:0]  mul_op;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic prod_first_ff, prod_neg_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base, addend, acc_half, acc_shr;

   logic signed [SIG_W-1:0] x_ff, x_in, y_sat, wb_x_ff, wb_h0_ff, wb_h2_ff;
   logic [SEC_W-1:0] wb_sec_ff;
   logic y_flag, flag_ff;

   logic signed [OUT_W-1:0] out_half, out_shr;
   logic signed [SAMPLE_W-1:0] out_sat;
   logic out_flag;
   rsp_type rsp_data_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign req_beat    = req_valid & req_ready;
   assign filter_beat = req_beat && (req_data.command == CMD_FILTER);
   assign clear_beat  = req_beat && (req_data.command == CMD_CLEAR);
   assign load_we     = req_beat && (req_data.command == CMD_LOAD)
                        && (32'(req_data.section_index) < MAX_SECTIONS)
                        && (32'(req_data.coefficient_slot) < SLOTS);
   assign last_term   = (state_ff == ST_RUN) && (term_ff == TERM_X0);

   always_comb begin
      if (sections_ff == '0) begin
         cfg_last = '0;
      end else if (32'(sections_ff) > MAX_SECTIONS) begin
         cfg_last = SEC_W'(MAX_SECTIONS - 1);
      end else begin
         cfg_last = SEC_W'(sections_ff - 1'b1);
      end
   end

   always_comb begin
      if (state_ff != ST_RUN) begin
         rd_sec = '0;
      end else if (term_ff == TERM_X0 && sec_ff != last_ff) begin
         rd_sec = sec_ff + 1'b1;
      end else begin
         rd_sec = sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sec_in       = sec_ff;
      term_in      = term_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SEC_W'(MAX_SECTIONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (filter_beat) begin
               state_in = ST_RUN;
               sec_in   = '0;
               term_in  = TERM_X1;
               last_in  = cfg_last;
            end
         end
         ST_RUN: begin
            if (term_ff == TERM_X0) begin
               term_in = TERM_X1;
               sec_in  = sec_ff + 1'b1;
               if (sec_ff == last_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (wb2_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = ST_IDLE;
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         sec_ff        <= '0;
         term_ff       <= TERM_X1;
         last_ff       <= '0;
         sections_ff   <= CFG_W'(1);
         rsp_valid_ff  <= 1'b0;
         prod_vld_ff   <= 1'b0;
         wb1_ff        <= 1'b0;
         wb2_ff        <= 1'b0;
         hist_valid_ff <= '0;
      end else begin
         clr_ff       <= clr_in;
         sec_ff       <= sec_in;
         term_ff      <= term_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         prod_vld_ff  <= (state_ff == ST_RUN);
         wb1_ff       <= last_term;
         wb2_ff       <= wb1_ff;
         if (csr_wr_en) begin
            sections_ff <= csr_wr_data;
         end
         if (clear_beat) begin
            hist_valid_ff <= '0;
         end else if (wb2_ff) begin
            hist_valid_ff[wb_sec_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         coef_mem[clr_ff] <= '0;
      end else if (load_we) begin
         coef_mem[SEC_W'(req_data.section_index)][req_data.coefficient_slot]
            <= req_data.coefficient_value;
      end
      coef_row_ff <= coef_mem[rd_sec];
   end

   always_ff @(posedge clock) begin
      if (wb2_ff) begin
         hist_mem[wb_sec_ff] <= hist_wr;
      end
      hist_row_ff <= hist_mem[rd_sec];
   end

   always_comb begin
      hist_use = hist_ok_ff ? hist_row_ff : '0;
      case (term_ff)
         TERM_X1: begin
            mul_op = hist_use[H_X1];
            mul_c  = coef_row_ff[SLOT_B1];
         end
         TERM_X2: begin
            mul_op = hist_use[H_X2];
            mul_c  = coef_row_ff[SLOT_B2];
         end
         TERM_Y1: begin
            mul_op = hist_use[H_Y1];
            mul_c  = coef_row_ff[SLOT_A1];
         end
         TERM_Y2: begin
            mul_op = hist_use[H_Y2];
            mul_c  = coef_row_ff[SLOT_A2];
         end
         default: begin
            mul_op = x_ff;
            mul_c  = coef_row_ff[SLOT_B0];
         end
      endcase
      prod_in = mul_c * mul_op;
   end

   always_comb begin
      acc_base = prod_first_ff ? '0 : acc_ff;
      addend   = ACC_W'(prod_ff);
      acc_in   = prod_neg_ff ? acc_base - addend : acc_base + addend;

      acc_half = acc_ff + ACC_HALF;
      acc_shr  = acc_half >>> COEF_FRAC;
      y_flag   = (acc_shr > ACC_SIG_MAX) || (acc_shr < ACC_SIG_MIN);
      if (acc_shr > ACC_SIG_MAX) begin
         y_sat = SIG_MAX;
      end else if (acc_shr < ACC_SIG_MIN) begin
         y_sat = SIG_MIN;
      end else begin
         y_sat = acc_shr[SIG_W-1:0];
      end

      hist_wr       = '0;
      hist_wr[H_X1] = wb_x_ff;
      hist_wr[H_X2] = wb_h0_ff;
      hist_wr[H_Y1] = y_sat;
      hist_wr[H_Y2] = wb_h2_ff;

      x_in     = {req_data.sample_in, {SHIFT{1'b0}}};
      out_half = {x_ff[SIG_W-1], x_ff} + OUT_HALF;
      out_shr  = out_half >>> SHIFT;
      out_flag = (out_shr > OUT_MAX) || (out_shr < OUT_MIN);
      if (out_shr > OUT_MAX) begin
         out_sat = SMP_MAX;
      end else if (out_shr < OUT_MIN) begin
         out_sat = SMP_MIN;
      end else begin
         out_sat = out_shr[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      hist_ok_ff    <= hist_valid_ff[rd_sec];
      prod_ff       <= prod_in;
      prod_first_ff <= (term_ff == TERM_X1);
      prod_neg_ff   <= (term_ff == TERM_Y1) || (term_ff == TERM_Y2);
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (last_term) begin
         wb_sec_ff <= sec_ff;
         wb_x_ff   <= x_ff;
         wb_h0_ff  <= hist_use[H_X1];
         wb_h2_ff  <= hist_use[H_Y1];
      end
      if (wb2_ff) begin
         x_ff    <= y_sat;
         flag_ff <= flag_ff | y_flag;
      end else if (filter_beat) begin
         x_ff    <= x_in;
         flag_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_data_ff.sample_out <= out_sat;
         rsp_data_ff.saturated  <= flag_ff | out_flag;
      end
   end

endmodule

// ===== hdl/bqc_checker.sv =====
// Port-level checks for the biquad cascade filter, bound to the top level.
module bqc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bqc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bqc_pkg::rsp_type rsp_data
);
   import bqc_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_FILTER |=> !req_ready)
      else $error("ready right after a filter beat");

   a_other_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command != CMD_FILTER |=> req_ready)
      else $error("load, clear or unknown beat stalled the block");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during the coefficient clearing pass");

   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while the block is still busy");

endmodule

bind biquad_cascade_iir_filter bqc_checker u_bqc_checker (.*);

// ===== tb/biquad_cascade_iir_filter_tb.sv =====
// Self-checking testbench for the biquad cascade filter: random beats, shadow model, scoreboard.
module biquad_cascade_iir_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bqc_pkg::*;

   localparam int SEC_COUNT     = 16;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 1500;
   localparam int PHASE_BEATS   = 190;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   logic signed [COEF_W-1:0] coef_store [SEC_COUNT][SLOTS];
   logic signed [SIG_W-1:0]  hist_store [SEC_COUNT][HIST];
   logic [CFG_W-1:0]         sections_cfg = 5'd1;

   req_type beats_to_send [$];
   rsp_type expected_samples [$];

   logic idle_on = 1'b1;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   send_gap      = 0;
   int   stall_left    = 0;
   int   n_samples = 0, n_loads = 0, n_clears = 0, n_unknown = 0;
   int   n_results = 0, n_saturated = 0, errors = 0;

   biquad_cascade_iir_filter #(.MAX_SECTIONS(SEC_COUNT)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int bits, inout logic flag);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic req_type make_beat(logic [CMD_W-1:0] cmd, int smp, int sec, int slot,
                                         int val);
      req_type b;
      b.command           = cmd;
      b.sample_in         = SAMPLE_W'(smp);
      b.section_index     = SEC_IDX_W'(sec);
      b.coefficient_slot  = SLOT_W'(slot);
      b.coefficient_value = COEF_W'(val);
      return b;
   endfunction

   function automatic int pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return int'($urandom_range(0, 65535)) - 32768;
      if (r < 90) return int'($urandom_range(0, 4000)) - 2000;
      return $urandom_range(0, 1) ? 32767 : -32768;
   endfunction

   // keep |a1| + |a2| below one so the section stays stable
   function automatic int stable_coef();
      return int'($urandom_range(0, 60000)) - 30000;
   endfunction

   function automatic req_type random_beat(int eff);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return make_beat(CMD_FILTER, pick_sample(), $urandom_range(0, 15),
                          $urandom_range(0, 7), $urandom);
      if (r < 80)
         return make_beat(CMD_LOAD, $urandom, $urandom_range(0, eff - 1),
                          $urandom_range(0, SLOTS - 1), stable_coef());
      if (r < 85)
         return make_beat(CMD_CLEAR, $urandom, $urandom_range(0, 15),
                          $urandom_range(0, 7), $urandom);
      if (r < 90)
         return make_beat(CMD_UNUSED, $urandom, $urandom_range(0, 15), $urandom_range(0, 7),
                          $urandom);
      return make_beat(CMD_LOAD, $urandom, $urandom_range(0, 15), $urandom_range(0, 7),
                       $urandom);
   endfunction

   task automatic cascade_predict(input req_type b);
      longint  x, y, acc;
      int      count;
      logic    sat;
      rsp_type r;
      case (b.command)
         CMD_LOAD: begin
            if (b.coefficient_slot < SLOTS)
               coef_store[b.section_index][b.coefficient_slot] = b.coefficient_value;
         end
         CMD_CLEAR: begin
            foreach (hist_store[s, k]) hist_store[s][k] = '0;
         end
         CMD_FILTER: begin
            count = (sections_cfg == 0) ? 1 :
                    (sections_cfg > SEC_COUNT) ? SEC_COUNT : int'(sections_cfg);
            sat = 1'b0;
            x = longint'(b.sample_in) <<< (SIG_W - SAMPLE_W);
            y = x;
            for (int j = 0; j < count; j++) begin
               acc = longint'(coef_store[j][SLOT_B0]) * x
                   + longint'(coef_store[j][SLOT_B1]) * longint'(hist_store[j][H_X1])
                   + longint'(coef_store[j][SLOT_B2]) * longint'(hist_store[j][H_X2])
                   - longint'(coef_store[j][SLOT_A1]) * longint'(hist_store[j][H_Y1])
                   - longint'(coef_store[j][SLOT_A2]) * longint'(hist_store[j][H_Y2]);
               y = clamp(round_half_up(acc, COEF_FRAC), SIG_W, sat);
               hist_store[j][H_X2] = hist_store[j][H_X1];
               hist_store[j][H_X1] = SIG_W'(x);
               hist_store[j][H_Y2] = hist_store[j][H_Y1];
               hist_store[j][H_Y1] = SIG_W'(y);
               x = y;
            end
            y = clamp(round_half_up(y, SIG_W - SAMPLE_W), SAMPLE_W, sat);
            r.sample_out = SAMPLE_W'(y);
            r.saturated  = sat;
            expected_samples.push_back(r);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            cascade_predict(req_data);
            case (req_data.command)
               CMD_FILTER: n_samples++;
               CMD_LOAD:   n_loads++;
               CMD_CLEAR:  n_clears++;
               default:    n_unknown++;
            endcase
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (beats_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= beats_to_send.pop_front();
               send_gap  <= idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      int      g;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("result with no sample pending: sample_out %0d saturated %0b",
                      rsp_data.sample_out, rsp_data.saturated);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               n_results++;
               if (want.saturated) n_saturated++;
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want.sample_out, rsp_data.sample_out);
                  errors++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %0b, actual %0b",
                         want.saturated, rsp_data.saturated);
                  errors++;
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            stall_left   <= LONG_HOLD;
            rsp_ready    <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            g = idle_on ? pick_gap() : 0;
            rsp_ready  <= (g == 0);
            stall_left <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sections(input logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sections_cfg = v;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] plan [10];
      int               eff;
      foreach (coef_store[s, k]) coef_store[s][k] = '0;
      foreach (hist_store[s, k]) hist_store[s][k] = '0;
      plan = '{5'd1, 5'd0, 5'd2, 5'd16, 5'd31, 5'd5, 5'd17, 5'd1, 5'd3, 5'd8};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      beats_to_send.push_back(make_beat(CMD_FILTER, 32767, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_FILTER, -32768, 15, 7, -1));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B0, 65536));
      beats_to_send.push_back(make_beat(CMD_FILTER, 32767, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_FILTER, -32768, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B0, 32768));
      beats_to_send.push_back(make_beat(CMD_FILTER, 1, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_FILTER, -1, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B0, 524287));
      beats_to_send.push_back(make_beat(CMD_FILTER, 32767, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B0, -524288));
      beats_to_send.push_back(make_beat(CMD_FILTER, -32768, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, 5, 12345));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, 7, -524288));
      beats_to_send.push_back(make_beat(CMD_UNUSED, -1, 15, 7, -1));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B0, 65536));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B1, 32768));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_B2, -16384));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_A1, -30000));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 0, SLOT_A2, 20000));
      beats_to_send.push_back(make_beat(CMD_FILTER, 10000, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_FILTER, -20000, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_CLEAR, 0, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_FILTER, 0, 0, 0, 0));
      beats_to_send.push_back(make_beat(CMD_LOAD, 0, 15, SLOT_A2, -1));
      settle();

      foreach (plan[p]) begin
         write_sections(plan[p]);
         idle_on = (p != 7);
         eff = (plan[p] == 0) ? 1 : (plan[p] > SEC_COUNT) ? SEC_COUNT : int'(plan[p]);
         for (int s = 0; s < eff; s++)
            for (int k = 0; k < SLOTS; k++)
               beats_to_send.push_back(make_beat(CMD_LOAD, $urandom, s, k, stable_coef()));
         // stall the output long enough to back up the input
         if (p == 0) hold_requests++;
         for (int n = 0; n < PHASE_BEATS; n++) beats_to_send.push_back(random_beat(eff));
         settle();
      end

      $display("Sent %0d samples, %0d coefficient loads, %0d clears, %0d unknown commands",
               n_samples, n_loads, n_clears, n_unknown);
      $display("Checked %0d filtered outputs (%0d saturated) over section counts 0 to 31",
               n_results, n_saturated);
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("biquad_cascade_iir_filter verification clean");
      end else begin
         $display("biquad_cascade_iir_filter verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("biquad_cascade_iir_filter verification failed");
      $finish;
   end

endmodule
